### rtl/bf3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared widths, constants, types and helper functions of the 3x3 box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

    localparam int PIX_W        = 8;
    localparam int DIM_W        = 11;
    localparam int SLICE_W      = 10;
    localparam int SUM_W        = 12;
    localparam int CNT_W        = 21;
    localparam int CFG_IDX_W    = 2;
    localparam int ROW_LIMIT    = 1024;
    localparam int RESET_DIM    = 512;
    localparam int MAX_COLS_DEF = 1024;
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_W    = 2;
    localparam int OUT_CNT_W    = 3;
    localparam int DIV9_MUL     = 3641;
    localparam int DIV9_SHIFT   = 15;
    localparam int DIV9_PROD_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [CNT_W-1:0] total;
        logic             restart;
    } frame_cfg_t;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
        logic             last;
    } calc_t;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic             last;
        logic [PIX_W-1:0] fmin;
        logic [PIX_W-1:0] fmax;
    } result_t;

    // floor(x / 9) for x below 2304 by reciprocal multiply
    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] x);
        logic [DIV9_PROD_W-1:0] prod;
        prod = DIV9_PROD_W'(x) * DIV9_PROD_W'(DIV9_MUL);
        return prod[DIV9_SHIFT +: PIX_W];
    endfunction

    // zero acts as one, values above the limit act as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] limit);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > limit)
        begin
            r = limit;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/bf3_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bf3 channel interfaces
// Pixel input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface bf3_pix_if
    import bf3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             func;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output func, output pixel, input ready);
    modport sink   (input valid, input func, input pixel, output ready);
endinterface

interface bf3_res_if
    import bf3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] mean_value;
    logic             frame_last;
    logic [PIX_W-1:0] frame_min;
    logic [PIX_W-1:0] frame_max;

    modport source (output valid, output mean_value, output frame_last,
                    output frame_min, output frame_max, input ready);
    modport sink   (input valid, input mean_value, input frame_last,
                    input frame_min, input frame_max, output ready);
endinterface

interface bf3_cfg_if
    import bf3_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/bf3_slice.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_slice
// Line stores, raster counters, column sums and drain window; first stage.
// ----------------------------------------------------------------------------
module bf3_slice
    import bf3_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             acc,
    input  logic             func,
    input  logic [PIX_W-1:0] pixel,
    input  frame_cfg_t       fcfg,
    output calc_t            calc,
    output logic             busy
);

    localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [PIX_W-1:0]   upper_mem [MAX_COLS];
    logic [PIX_W-1:0]   lower_mem [MAX_COLS];

    logic               s1_valid_reg;
    logic               func_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W-1:0]   up_rd_reg;
    logic [PIX_W-1:0]   lo_rd_reg;
    logic               fwd_reg;
    logic [PIX_W-1:0]   fwd_up_reg;
    logic [PIX_W-1:0]   fwd_lo_reg;

    logic [DIM_W-1:0]   in_col_reg,    in_col_next;
    logic [DIM_W-1:0]   in_row_reg,    in_row_next;
    logic [CNT_W-1:0]   out_cnt_reg,   out_cnt_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [SUM_W-1:0]   pend_sum_reg,  pend_sum_next;
    logic [SLICE_W-1:0] cs1_reg,       cs1_next;
    logic [SLICE_W-1:0] cs2_reg,       cs2_next;
    logic [SLICE_W-1:0] dw_l_reg,      dw_l_next;
    logic [SLICE_W-1:0] dw_m_reg,      dw_m_next;
    logic [DIM_W-1:0]   drain_rd_reg,  drain_rd_next;

    logic [PIX_W-1:0]   up_val;
    logic [PIX_W-1:0]   lo_val;
    logic [PIX_W-1:0]   top_px;
    logic [PIX_W-1:0]   drain_top;
    logic [PIX_W-1:0]   init_top;
    logic [SLICE_W-1:0] slice_sum;
    logic [SLICE_W-1:0] drain_w;
    logic [SLICE_W-1:0] init_w;
    logic               input_done;
    logic               rows_multi;
    logic               cols_one;
    logic               last_col;
    logic               do_pixel;
    logic               do_drain;
    logic               we;
    logic               emit;
    logic               emit_last;
    logic [SUM_W-1:0]   emit_sum;
    logic [CNT_W-1:0]   cnt_inc;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               fwd_hit;

    always_comb
    begin
        up_val     = fwd_reg ? fwd_up_reg : up_rd_reg;
        lo_val     = fwd_reg ? fwd_lo_reg : lo_rd_reg;
        input_done = in_row_reg >= fcfg.rows;
        rows_multi = fcfg.rows != DIM_W'(1);
        cols_one   = fcfg.cols == DIM_W'(1);
        last_col   = in_col_reg == (fcfg.cols - DIM_W'(1));
        top_px     = (in_row_reg == DIM_W'(1)) ? lo_val : up_val;
        slice_sum  = SLICE_W'(top_px) + SLICE_W'(lo_val) + SLICE_W'(pix_reg);
        drain_top  = rows_multi ? up_val : lo_val;
        drain_w    = SLICE_W'(drain_top) + SLICE_W'({lo_val, 1'b0});
        init_top   = rows_multi ? lo_val : pix_reg;
        init_w     = SLICE_W'(init_top) + SLICE_W'({pix_reg, 1'b0});
        do_pixel   = s1_valid_reg && !func_reg && !input_done;
        do_drain   = s1_valid_reg && func_reg && input_done;

        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        out_cnt_next    = out_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_sum_next   = pend_sum_reg;
        cs1_next        = cs1_reg;
        cs2_next        = cs2_reg;
        dw_l_next       = dw_l_reg;
        dw_m_next       = dw_m_reg;
        drain_rd_next   = drain_rd_reg;
        we              = 1'b0;
        emit            = 1'b0;
        emit_sum        = '0;

        if (do_pixel)
        begin
            we = 1'b1;
            if (in_row_reg != '0)
            begin
                if (cols_one || in_col_reg == '0)
                begin
                    cs1_next = slice_sum;
                    cs2_next = slice_sum;
                    if (cols_one)
                    begin
                        emit     = 1'b1;
                        emit_sum = SUM_W'({slice_sum, 1'b0}) + SUM_W'(slice_sum);
                    end
                    else if (pend_valid_reg)
                    begin
                        emit            = 1'b1;
                        emit_sum        = pend_sum_reg;
                        pend_valid_next = 1'b0;
                    end
                end
                else
                begin
                    cs1_next = cs2_reg;
                    cs2_next = slice_sum;
                    if (last_col)
                    begin
                        pend_sum_next   = SUM_W'(cs2_reg) + SUM_W'({slice_sum, 1'b0});
                        pend_valid_next = 1'b1;
                    end
                    emit     = 1'b1;
                    emit_sum = SUM_W'(cs1_reg) + SUM_W'(cs2_reg) + SUM_W'(slice_sum);
                end
            end
            // last row, first column: seed the drain window
            if (in_row_reg == (fcfg.rows - DIM_W'(1)) && in_col_reg == '0)
            begin
                dw_l_next     = init_w;
                dw_m_next     = init_w;
                drain_rd_next = cols_one ? DIM_W'(0) : DIM_W'(1);
            end
            if (last_col)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + DIM_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + DIM_W'(1);
            end
        end

        if (do_drain)
        begin
            emit = 1'b1;
            if (pend_valid_reg)
            begin
                emit_sum        = pend_sum_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                emit_sum  = SUM_W'(dw_l_reg) + SUM_W'(dw_m_reg) + SUM_W'(drain_w);
                dw_l_next = dw_m_reg;
                dw_m_next = drain_w;
                if (drain_rd_reg != (fcfg.cols - DIM_W'(1)))
                begin
                    drain_rd_next = drain_rd_reg + DIM_W'(1);
                end
            end
        end

        cnt_inc   = out_cnt_reg + CNT_W'(1);
        emit_last = emit && (cnt_inc >= fcfg.total);
        if (emit)
        begin
            out_cnt_next = cnt_inc;
        end
        if (emit_last || fcfg.restart)
        begin
            in_col_next     = '0;
            in_row_next     = '0;
            out_cnt_next    = '0;
            pend_valid_next = 1'b0;
        end

        rd_addr = ADDR_W'(func ? drain_rd_next : in_col_next);
        wr_addr = ADDR_W'(in_col_reg);
        fwd_hit = we && (wr_addr == rd_addr);
    end

    // line stores, read every cycle at the address of the incoming transfer
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            upper_mem[wr_addr] <= lo_val;
            lower_mem[wr_addr] <= pix_reg;
        end
        up_rd_reg <= upper_mem[rd_addr];
        lo_rd_reg <= lower_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_reg        <= 1'b0;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= acc;
            fwd_reg        <= fwd_hit;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_cnt_reg    <= out_cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func;
        pix_reg      <= pixel;
        fwd_up_reg   <= lo_val;
        fwd_lo_reg   <= pix_reg;
        pend_sum_reg <= pend_sum_next;
        cs1_reg      <= cs1_next;
        cs2_reg      <= cs2_next;
        dw_l_reg     <= dw_l_next;
        dw_m_reg     <= dw_m_next;
        drain_rd_reg <= drain_rd_next;
    end

    assign calc.valid = emit;
    assign calc.sum   = emit_sum;
    assign calc.last  = emit_last;
    assign busy       = s1_valid_reg;

endmodule
`default_nettype wire

### rtl/bf3_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_stats
// Second stage: divide by nine and track the frame minimum and maximum.
// ----------------------------------------------------------------------------
module bf3_stats
    import bf3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    restart,
    input  calc_t   calc,
    output logic    push,
    output result_t push_data,
    output logic    busy
);

    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic             s2_last_reg;
    logic [PIX_W-1:0] min_reg, min_next;
    logic [PIX_W-1:0] max_reg, max_next;
    logic [PIX_W-1:0] mean;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;

    always_comb
    begin
        mean     = div9(s2_sum_reg);
        lo       = (mean < min_reg) ? mean : min_reg;
        hi       = (mean > max_reg) ? mean : max_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (restart || (s2_valid_reg && s2_last_reg))
        begin
            min_next = PIX_MAX;
            max_next = PIX_MIN;
        end
        else if (s2_valid_reg)
        begin
            min_next = lo;
            max_next = hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            min_reg      <= PIX_MAX;
            max_reg      <= PIX_MIN;
        end
        else
        begin
            s2_valid_reg <= calc.valid;
            min_reg      <= min_next;
            max_reg      <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_sum_reg  <= calc.sum;
        s2_last_reg <= calc.last;
    end

    assign push           = s2_valid_reg;
    assign push_data.mean = mean;
    assign push_data.last = s2_last_reg;
    assign push_data.fmin = lo;
    assign push_data.fmax = hi;
    assign busy           = s2_valid_reg;

endmodule
`default_nettype wire

### rtl/bf3_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_out_fifo
// Small result queue that decouples the pipeline from the result receiver.
// ----------------------------------------------------------------------------
module bf3_out_fifo
    import bf3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  result_t              push_data,
    bf3_res_if.source            res,
    output logic [OUT_CNT_W-1:0] count
);

    result_t                entries [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;
    result_t                head;

    always_comb
    begin
        pop        = res.valid && res.ready;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + OUT_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
        head = entries[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign res.valid      = count_reg != '0;
    assign res.mean_value = head.mean;
    assign res.frame_last = head.last;
    assign res.frame_min  = head.fmin;
    assign res.frame_max  = head.fmax;
    assign count          = count_reg;

endmodule
`default_nettype wire

### rtl/box_filter_3x3_replicate_border_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_3x3_replicate_border_core
// Streaming 3x3 mean filter with replicated border and per-frame min/max.
//
// pix carries one transfer per item: func 0 is a raster-order pixel, func 1 a
// drain tick that releases one pending result once the frame's pixels are in.
// res returns the truncated 3x3 mean with frame_last, frame_min and frame_max.
// cfg writes image_rows (index 0) and image_cols (index 1); ready is always
// high and a write to either restarts the frame.
// Throughput is one item per cycle while pix.ready is high. A result passes
// the line store read stage, the divide and min/max stage, then the result
// queue. Results run about one row behind pixels.
// When res stalls, a four-entry result queue absorbs the items in flight and
// pix.ready drops once queue and pipeline together hold four items.
// Reset clears counters, pending result and min/max and sets the frame to
// 512 x 512; the line stores are not cleared, since no result reads an entry
// that the current frame has not written.
// ----------------------------------------------------------------------------
module box_filter_3x3_replicate_border_core
    import bf3_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bf3_pix_if.sink    pix,
    bf3_res_if.source  res,
    bf3_cfg_if.sink    cfg
);

    localparam int COL_LIMIT  = (MAX_COLS < ROW_LIMIT) ? MAX_COLS : ROW_LIMIT;
    localparam int RESET_COLS = (RESET_DIM < COL_LIMIT) ? RESET_DIM : COL_LIMIT;
    localparam int PROD_W     = 2 * DIM_W;

    logic [DIM_W-1:0]     rows_reg;
    logic [DIM_W-1:0]     cols_reg;
    logic [CNT_W-1:0]     total_reg;
    logic [PROD_W-1:0]    prod;
    logic                 cfg_wr;
    logic                 restart;
    frame_cfg_t           fcfg;
    logic                 acc;
    calc_t                calc;
    logic                 s1_busy;
    logic                 s2_busy;
    logic                 push;
    result_t              push_data;
    logic [OUT_CNT_W-1:0] fifo_count;
    logic [OUT_CNT_W-1:0] occupancy;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign restart   = cfg_wr && (cfg.index == CFG_ROWS || cfg.index == CFG_COLS);
    assign prod      = PROD_W'(rows_reg) * PROD_W'(cols_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_W'(RESET_DIM);
            cols_reg  <= DIM_W'(RESET_COLS);
            total_reg <= CNT_W'(RESET_DIM * RESET_COLS);
        end
        else
        begin
            if (cfg_wr && cfg.index == CFG_ROWS)
            begin
                rows_reg <= clamp_dim(cfg.data, DIM_W'(ROW_LIMIT));
            end
            if (cfg_wr && cfg.index == CFG_COLS)
            begin
                cols_reg <= clamp_dim(cfg.data, DIM_W'(COL_LIMIT));
            end
            total_reg <= prod[CNT_W-1:0];
        end
    end

    assign fcfg.rows    = rows_reg;
    assign fcfg.cols    = cols_reg;
    assign fcfg.total   = total_reg;
    assign fcfg.restart = restart;

    assign occupancy = fifo_count + OUT_CNT_W'(s1_busy) + OUT_CNT_W'(s2_busy);
    assign pix.ready = occupancy < OUT_CNT_W'(OUT_DEPTH);
    assign acc       = pix.valid && pix.ready;

    bf3_slice #(
        .MAX_COLS (MAX_COLS)
    ) u_slice (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .func  (pix.func),
        .pixel (pix.pixel),
        .fcfg  (fcfg),
        .calc  (calc),
        .busy  (s1_busy)
    );

    bf3_stats u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .calc      (calc),
        .push      (push),
        .push_data (push_data),
        .busy      (s2_busy)
    );

    bf3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .res       (res),
        .count     (fifo_count)
    );

    // queue plus in-flight items never exceed the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overcommitted");

    // first stage only holds an item accepted in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_busy |-> $past(pix.valid && pix.ready))
        else $error("first stage busy without a transfer");

    // a result lies within the frame's running bounds
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.frame_min <= res.mean_value && res.mean_value <= res.frame_max))
        else $error("frame min/max inconsistent with result");

endmodule
`default_nettype wire

### tb/box_filter_3x3_replicate_border_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_3x3_replicate_border_core_tb
// Self-checking bench for the streaming 3x3 mean filter. A short table of
// directed steps covers one-pixel frames, ignored drains and pixels, writes to
// unused register indexes and a restart in mid-frame. Random frames follow:
// many small ones with random content, cut-off frames and stray items. A
// behavioral model of the line stores, window and frame counters predicts
// every result, and a monitor checks each result transfer against the oldest
// prediction. Both channels stall at random.
// ----------------------------------------------------------------------------
module box_filter_3x3_replicate_border_core_tb;
    import bf3_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SMALL_ITEMS   = 1250;
    localparam int DIRECTED_LEN  = 35;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam result_t NO_RESULT = '0;

    typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [DIM_W-1:0]     data;
        logic                 func;
        logic [PIX_W-1:0]     pixel;
        logic                 typed;
        result_t              want;
    } dir_row_t;

    dir_row_t directed_rows [0:DIRECTED_LEN-1] = '{
        // one-pixel frames, stray drains and pixels
        '{ROW_WRITE, CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_COLS,    11'd0,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_DRAIN, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd255, 1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_DRAIN, 8'd0,   1'b1,
          '{8'd255, 1'b1, 8'd255, 8'd255}},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_DRAIN, 8'd77,  1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd200, 1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_DRAIN, 8'd255, 1'b1,
          '{8'd0, 1'b1, 8'd0, 8'd0}},
        // 2x2 with unused register writes in mid-frame
        '{ROW_WRITE, CFG_ROWS,    11'd2,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_COLS,    11'd2,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd255, 1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_SPARE_A, 11'd2047, FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_SPARE_B, 11'd0,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd255, 1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_DRAIN, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_DRAIN, 8'd0,   1'b0, NO_RESULT},
        // single column
        '{ROW_WRITE, CFG_ROWS,    11'd3,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_COLS,    11'd1,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd10,  1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd20,  1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd30,  1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_DRAIN, 8'd0,   1'b0, NO_RESULT},
        // single row, restarted after its first pixel
        '{ROW_WRITE, CFG_ROWS,    11'd1,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_COLS,    11'd3,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd9,   1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_COLS,    11'd3,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd255, 1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_PIXEL, 8'd128, 1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_DRAIN, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_DRAIN, 8'd0,   1'b0, NO_RESULT},
        '{ROW_ITEM,  CFG_ROWS,    11'd0,    FUNC_DRAIN, 8'd0,   1'b0, NO_RESULT}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic calm;

    bf3_pix_if pix_ch ();
    bf3_res_if res_ch ();
    bf3_cfg_if cfg_ch ();

    box_filter_3x3_replicate_border_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // filter model state
    logic [PIX_W-1:0] upper_row [MAX_COLS_DEF];
    logic [PIX_W-1:0] lower_row [MAX_COLS_DEF];
    logic [PIX_W-1:0] win [9];
    int unsigned      in_col;
    int unsigned      in_row;
    logic [CNT_W-1:0] out_cnt;
    logic [PIX_W-1:0] lo_mean;
    logic [PIX_W-1:0] hi_mean;
    logic             held_valid;
    logic [PIX_W-1:0] held_mean;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    int unsigned      frames_closed;

    result_t     awaited_means [$];
    result_t     head_mean;
    int unsigned fail_count;
    int unsigned idle_cycles;
    int unsigned small_items;

    function automatic int unsigned clip_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > ROW_LIMIT)
        begin
            return ROW_LIMIT;
        end
        return 32'(v);
    endfunction

    function automatic void restart_frame();
        for (int k = 0; k < 9; k++)
        begin
            win[k] = '0;
        end
        in_col     = 0;
        in_row     = 0;
        out_cnt    = '0;
        lo_mean    = PIX_MAX;
        hi_mean    = PIX_MIN;
        held_valid = 1'b0;
        held_mean  = '0;
    endfunction

    function automatic logic [PIX_W-1:0] window_mean(input int a, input int b, input int c);
        int unsigned s;
        s = 0;
        for (int r = 0; r < 3; r++)
        begin
            s += 32'(win[a*3+r]) + 32'(win[b*3+r]) + 32'(win[c*3+r]);
        end
        return PIX_W'(s / 9);
    endfunction

    function automatic result_t emit_mean(input logic [PIX_W-1:0] v);
        result_t     r;
        int unsigned total;
        total   = clip_dim(rows_reg) * clip_dim(cols_reg);
        out_cnt = out_cnt + CNT_W'(1);
        if (v < lo_mean)
        begin
            lo_mean = v;
        end
        if (v > hi_mean)
        begin
            hi_mean = v;
        end
        r.mean = v;
        r.last = (32'(out_cnt) >= total);
        r.fmin = lo_mean;
        r.fmax = hi_mean;
        if (r.last)
        begin
            frames_closed++;
            restart_frame();
        end
        return r;
    endfunction

    function automatic void load_column(input int c, input logic [PIX_W-1:0] t,
                                        input logic [PIX_W-1:0] m, input logic [PIX_W-1:0] b);
        win[c*3]   = t;
        win[c*3+1] = m;
        win[c*3+2] = b;
    endfunction

    function automatic logic slice_in(input int unsigned j, input int unsigned cols,
                                      input logic [PIX_W-1:0] t, input logic [PIX_W-1:0] m,
                                      input logic [PIX_W-1:0] b, output result_t r);
        r = NO_RESULT;
        if (cols == 1 || j == 0)
        begin
            for (int c = 0; c < 3; c++)
            begin
                load_column(c, t, m, b);
            end
            if (cols == 1)
            begin
                r = emit_mean(window_mean(0, 1, 2));
                return 1'b1;
            end
            if (held_valid)
            begin
                held_valid = 1'b0;
                r = emit_mean(held_mean);
                return 1'b1;
            end
            return 1'b0;
        end
        for (int k = 0; k < 6; k++)
        begin
            win[k] = win[k+3];
        end
        load_column(2, t, m, b);
        if (j == cols - 1)
        begin
            held_mean  = window_mean(1, 2, 2);
            held_valid = 1'b1;
        end
        r = emit_mean(window_mean(0, 1, 2));
        return 1'b1;
    endfunction

    function automatic logic drain_out(input int unsigned rows, input int unsigned cols,
                                       output result_t r);
        int unsigned base;
        int unsigned col;
        int unsigned cl;
        int unsigned cr;
        int unsigned s;
        r = NO_RESULT;
        if (held_valid)
        begin
            held_valid = 1'b0;
            r = emit_mean(held_mean);
            return 1'b1;
        end
        base = (rows - 1) * cols;
        if (32'(out_cnt) < base)
        begin
            return 1'b0;
        end
        col = 32'(out_cnt) - base;
        if (col >= cols)
        begin
            return 1'b0;
        end
        cl = (col == 0) ? 0 : col - 1;
        cr = (col + 1 < cols) ? col + 1 : cols - 1;
        if (rows >= 2)
        begin
            s = 32'(upper_row[cl]) + 32'(upper_row[col]) + 32'(upper_row[cr]);
        end
        else
        begin
            s = 32'(lower_row[cl]) + 32'(lower_row[col]) + 32'(lower_row[cr]);
        end
        s += 2 * (32'(lower_row[cl]) + 32'(lower_row[col]) + 32'(lower_row[cr]));
        r = emit_mean(PIX_W'(s / 9));
        return 1'b1;
    endfunction

    // one accepted pixel or drain; returns 1 when a result is due
    function automatic logic box_mean_step(input logic f, input logic [PIX_W-1:0] p,
                                           output result_t r);
        int unsigned      rows;
        int unsigned      cols;
        int unsigned      i;
        int unsigned      j;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] l;
        logic             got;
        rows = clip_dim(rows_reg);
        cols = clip_dim(cols_reg);
        r    = NO_RESULT;
        if (f == FUNC_DRAIN)
        begin
            return (in_row >= rows) ? drain_out(rows, cols, r) : 1'b0;
        end
        if (in_row >= rows)
        begin
            return 1'b0;
        end
        i = in_row;
        j = (in_col >= cols) ? cols - 1 : in_col;
        u = upper_row[j];
        l = lower_row[j];
        upper_row[j] = l;
        lower_row[j] = p;
        got = 1'b0;
        if (i >= 1)
        begin
            got = slice_in(j, cols, (i == 1) ? l : u, l, p, r);
        end
        j++;
        if (j >= cols)
        begin
            j = 0;
            in_row = (i + 1) & 32'h7FF;
        end
        in_col = j;
        return got;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DIM_W-1:0] data);
        case (idx)
            CFG_ROWS:
            begin
                rows_reg = data;
                restart_frame();
            end
            CFG_COLS:
            begin
                cols_reg = data;
                restart_frame();
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned mode,
                                                    input logic [PIX_W-1:0] seed_val);
        case (mode)
            0: return PIX_W'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
            2: return seed_val ^ PIX_W'($urandom_range(0, 7));
            default: return seed_val;
        endcase
    endfunction

    task automatic send_item(input logic f, input logic [PIX_W-1:0] p, input logic typed,
                             input result_t want);
        result_t got;
        logic    made;
        while (!calm && $urandom_range(0, 99) < 30)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.func  <= f;
        pix_ch.pixel <= p;
        @(posedge clk);
        while (!pix_ch.ready)
        begin
            @(posedge clk);
        end
        made = box_mean_step(f, p, got);
        if (made || typed)
        begin
            awaited_means.push_back(typed ? want : got);
        end
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        pix_ch.valid <= 1'b0;
        while (awaited_means.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        hold_until_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        apply_reg(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_frame(input logic [DIM_W-1:0] rows_val, input logic [DIM_W-1:0] cols_val,
                             output int unsigned sent);
        int unsigned      n_pix;
        int unsigned      ecols;
        int unsigned      mode;
        int unsigned      closed_at;
        logic [PIX_W-1:0] seed_val;
        sent = 0;
        if ($urandom_range(0, 99) < 10)
        begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      DIM_W'($urandom_range(0, 2047)));
        end
        write_reg(CFG_ROWS, rows_val);
        write_reg(CFG_COLS, cols_val);
        ecols    = clip_dim(cols_val);
        n_pix    = clip_dim(rows_val) * ecols;
        mode     = $urandom_range(0, 3);
        seed_val = PIX_W'($urandom_range(0, 255));
        // frame abandoned inside its first row, then restarted by the next rows or cols write
        if (ecols > 1 && $urandom_range(0, 99) < 10)
        begin
            repeat ($urandom_range(1, ecols - 1))
            begin
                send_item(FUNC_PIXEL, pick_pixel(mode, seed_val), 1'b0, NO_RESULT);
                sent++;
            end
            return;
        end
        closed_at = frames_closed;
        for (int unsigned k = 0; k < n_pix; k++)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                send_item(FUNC_DRAIN, PIX_W'($urandom_range(0, 255)), 1'b0, NO_RESULT);
            end
            if ($urandom_range(0, 999) < 8)
            begin
                hold_until_drained();
            end
            send_item(FUNC_PIXEL, pick_pixel(mode, seed_val), 1'b0, NO_RESULT);
            sent++;
        end
        if ($urandom_range(0, 99) < 30)
        begin
            send_item(FUNC_PIXEL, PIX_W'($urandom_range(0, 255)), 1'b0, NO_RESULT);
        end
        while (frames_closed == closed_at)
        begin
            send_item(FUNC_DRAIN, PIX_W'($urandom_range(0, 255)), 1'b0, NO_RESULT);
            sent++;
        end
    endtask

    always @(negedge clk)
    begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // result transfer check
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_means.size() == 0)
            begin
                $error("unexpected result: mean_value %0d", res_ch.mean_value);
                fail_count++;
            end
            else
            begin
                head_mean = awaited_means.pop_front();
                if (res_ch.mean_value !== head_mean.mean)
                begin
                    $error("mean_value: expected %0d, actual %0d",
                           head_mean.mean, res_ch.mean_value);
                    fail_count++;
                end
                if (res_ch.frame_last !== head_mean.last)
                begin
                    $error("frame_last: expected %0d, actual %0d",
                           head_mean.last, res_ch.frame_last);
                    fail_count++;
                end
                if (res_ch.frame_min !== head_mean.fmin)
                begin
                    $error("frame_min: expected %0d, actual %0d",
                           head_mean.fmin, res_ch.frame_min);
                    fail_count++;
                end
                if (res_ch.frame_max !== head_mean.fmax)
                begin
                    $error("frame_max: expected %0d, actual %0d",
                           head_mean.fmax, res_ch.frame_max);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("box_filter_3x3_replicate_border_core test failed");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t         row;
        int unsigned      got;
        logic [DIM_W-1:0] rows_val;
        logic [DIM_W-1:0] cols_val;
        int unsigned      pick;
        pix_ch.valid  = 1'b0;
        pix_ch.func   = FUNC_PIXEL;
        pix_ch.pixel  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_ROWS;
        cfg_ch.data   = '0;
        res_ch.ready  = 1'b0;
        calm          = 1'b0;
        fail_count    = 0;
        idle_cycles   = 0;
        small_items   = 0;
        frames_closed = 0;
        for (int k = 0; k < MAX_COLS_DEF; k++)
        begin
            upper_row[k] = '0;
            lower_row[k] = '0;
        end
        rows_reg = DIM_W'(RESET_DIM);
        cols_reg = DIM_W'(RESET_DIM);
        restart_frame();
        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (int n = 0; n < DIRECTED_LEN; n++)
        begin
            row = directed_rows[n];
            if (row.kind == ROW_WRITE)
            begin
                write_reg(row.index, row.data);
            end
            else
            begin
                send_item(row.func, row.pixel, row.typed, row.want);
            end
        end

        while (small_items < SMALL_ITEMS)
        begin
            calm = (small_items >= 300 && small_items < 600);
            rows_val = ($urandom_range(0, 99) < 5) ? '0 : DIM_W'($urandom_range(1, 6));
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                cols_val = '0;
            end
            else if (pick < 15)
            begin
                cols_val = DIM_W'($urandom_range(11, 40));
            end
            else
            begin
                cols_val = DIM_W'($urandom_range(1, 10));
            end
            run_frame(rows_val, cols_val, got);
            small_items += got;
        end
        calm = 1'b0;

        hold_until_drained();
        if (fail_count == 0)
        begin
            $display("box_filter_3x3_replicate_border_core test passed");
        end
        else
        begin
            $display("box_filter_3x3_replicate_border_core test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
